@@ hw/rtl/isg_pkg.sv @@
package isg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_INSET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVL_NUM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVL_DEN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TINY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_NUM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DEN = 3'd5;

	localparam logic [7:0]  RST_INSET    = 8'd32;
	localparam logic [4:0]  RST_OVL_NUM  = 5'd2;
	localparam logic [4:0]  RST_OVL_DEN  = 5'd5;
	localparam logic [11:0] RST_TINY     = 12'd128;
	localparam logic [4:0]  RST_NEAR_NUM = 5'd6;
	localparam logic [4:0]  RST_NEAR_DEN = 5'd5;

	typedef struct packed {
		logic [31:0]        stroke_id;
		logic               is_pen;
		logic               has_points;
		logic signed [19:0] box_left;
		logic signed [19:0] box_top;
		logic signed [19:0] box_right;
		logic signed [19:0] box_bottom;
		logic               set_last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_stroke_id;
		logic [5:0]  line_index;
		logic        line_end;
		logic        set_end;
		logic        overflow;
	} out_item_t;

	// raw stroke box as received
	typedef struct packed {
		logic signed [19:0] l;
		logic signed [19:0] t;
		logic signed [19:0] r;
		logic signed [19:0] b;
	} box20_t;

	// inset box, one bit wider
	typedef struct packed {
		logic signed [20:0] l;
		logic signed [20:0] t;
		logic signed [20:0] r;
		logic signed [20:0] b;
	} box21_t;

	localparam int BOX20_W = $bits(box20_t);
	localparam int BOX21_W = $bits(box21_t);

	function automatic logic signed [20:0] mn21(logic signed [20:0] a, logic signed [20:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [20:0] mx21(logic signed [20:0] a, logic signed [20:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic box21_t shrink(box20_t bx, logic [7:0] m);
		box21_t r;
		logic signed [20:0] mg;
		mg = 21'({1'b0, m});
		r.l = 21'(bx.l) + mg;
		r.t = 21'(bx.t) + mg;
		r.r = 21'(bx.r) - mg;
		r.b = 21'(bx.b) - mg;
		return r;
	endfunction

	// union; a box with zero width and zero height does not count
	function automatic box21_t unite(box21_t d, box21_t s);
		box21_t r;
		if (d.r == d.l && d.b == d.t) begin
			r = s;
		end else if (s.r == s.l && s.b == s.t) begin
			r = d;
		end else begin
			r.l = mn21(mn21(d.l, d.r), mn21(s.l, s.r));
			r.r = mx21(mx21(d.l, d.r), mx21(s.l, s.r));
			r.t = mn21(mn21(d.t, d.b), mn21(s.t, s.b));
			r.b = mx21(mx21(d.t, d.b), mx21(s.t, s.b));
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/isg_ram.sv @@
module isg_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ink_stroke_line_grouper.sv @@
// Stroke line grouper. Strokes come in one item at a time; pen strokes with
// points are stored (up to MAX_STROKES per set, extras dropped and flagged).
// A stroke without set_last is taken without a stall. The set_last item of a
// set with kept strokes starts grouping, during which in_stall is high:
// sorting and line assignment, then merging of tiny marks, then emitting the
// results, which the output stall can hold. Every step walks stroke and line
// memories with one read port an entry at a time (address, then registered
// data).
module ink_stroke_line_grouper #(
	parameter int MAX_STROKES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  isg_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output isg_pkg::out_item_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [isg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [isg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import isg_pkg::*;

	localparam int AW = $clog2(MAX_STROKES);
	localparam int CW = $clog2(MAX_STROKES + 1);
	localparam int LW = BOX21_W + CW;

	typedef enum logic [22:0] {
		ST_IDLE  = 23'h000001,
		ST_S_RD  = 23'h000002,
		ST_S_EV  = 23'h000004,
		ST_A_RD  = 23'h000008,
		ST_A_EV  = 23'h000010,
		ST_A_DO  = 23'h000020,
		ST_M_RDA = 23'h000040,
		ST_M_EVA = 23'h000080,
		ST_M_RD  = 23'h000100,
		ST_M_EV  = 23'h000200,
		ST_M_WR  = 23'h000400,
		ST_M_NXT = 23'h000800,
		ST_R_RD  = 23'h001000,
		ST_R_EV  = 23'h002000,
		ST_H_RD  = 23'h004000,
		ST_H_EV  = 23'h008000,
		ST_T_RD  = 23'h010000,
		ST_T_EV  = 23'h020000,
		ST_P_RD  = 23'h040000,
		ST_P_EV  = 23'h080000,
		ST_P_ID  = 23'h100000,
		ST_P_LD  = 23'h200000,
		ST_OUT   = 23'h400000
	} state_t;

	state_t state_q;

	logic [7:0]  inset_q;
	logic [4:0]  ovn_q, ovd_q, nn_q, nd_q;
	logic [11:0] tiny_q;

	logic [CW-1:0] cnt_q, lc_q, rank_q;
	logic          drop_q;
	logic [AW-1:0] idx_q, a_q, bi_q, bl_q, L_q, pi_q, lpi_q;
	logic signed [21:0] pk_q, bk_q, lpk_q, lbk_q;
	logic          hp_q, lhp_q, bf_q, af_q, more_q;
	logic signed [23:0] bestov_q, bd_q;
	box21_t        skb_q, abox_q, lbox_q;
	logic [CW-1:0] lsize_q;
	logic          out_valid_q;
	out_item_t     out_q;

	// memories
	logic              st_we;
	logic [AW-1:0]     st_waddr;
	logic [31:0]       id_rd;
	logic [BOX20_W-1:0] sbox_rd;
	logic              sl_we;
	logic [AW-1:0]     sl_waddr, sl_wdata, sl_rd;
	logic              ln_we;
	logic [AW-1:0]     ln_waddr, ln_raddr;
	logic [LW-1:0]     ln_wdata, ln_rd;

	isg_ram #(.W(32), .D(MAX_STROKES)) u_ids (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(in_data.stroke_id),
		.raddr(bi_q), .rdata(id_rd)
	);

	isg_ram #(.W(BOX20_W), .D(MAX_STROKES)) u_sbox (
		.clk(clk), .we(st_we), .waddr(st_waddr),
		.wdata({in_data.box_left, in_data.box_top, in_data.box_right, in_data.box_bottom}),
		.raddr(idx_q), .rdata(sbox_rd)
	);

	isg_ram #(.W(AW), .D(MAX_STROKES)) u_sline (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.raddr(idx_q), .rdata(sl_rd)
	);

	isg_ram #(.W(LW), .D(MAX_STROKES)) u_lines (
		.clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
		.raddr(ln_raddr), .rdata(ln_rd)
	);

	box20_t        raw;
	box21_t        lbx, skb_new, un_a, un_m;
	logic [CW-1:0] lsz, lc_m1;
	logic          keep, full;
	logic          last_n, last_l, h_last, a_top;
	logic signed [21:0] skey, tkey, pkey;
	logic          stake, ttake, ptake, pcand;
	logic signed [23:0] lt, lb, st, sb, ov, rf, c2, hh, ww, tiny24, ca, dd, dabs, hk;
	logic signed [31:0] p_ov, p_rf, p_d, p_h;
	logic          a_take, m_take, tiny_ok;
	logic [AW-1:0] rel_v1, rel_v2, a_next;

	always_comb begin
		raw     = box20_t'(sbox_rd);
		lbx     = box21_t'(ln_rd[BOX21_W-1:0]);
		lsz     = ln_rd[LW-1 -: CW];
		skb_new = shrink(raw, inset_q);
		un_a    = unite(lbox_q, skb_q);
		un_m    = unite(lbox_q, abox_q);
		lc_m1   = lc_q - CW'(1);
		a_next  = af_q ? lc_m1[AW-1:0] : lc_q[AW-1:0];

		keep = in_data.is_pen && in_data.has_points;
		full = (cnt_q >= CW'(MAX_STROKES));

		last_n = (CW'(idx_q) + CW'(1)) == cnt_q;
		last_l = (CW'(idx_q) + CW'(1)) == lc_q;
		h_last = (CW'(idx_q) + CW'(2)) == lc_q;
		a_top  = (CW'(a_q) + CW'(1)) == lc_q;

		// stroke order by vertical centre; the inset cancels in t + b
		skey  = 22'(raw.t) + 22'(raw.b);
		stake = (!hp_q || skey > pk_q || (skey == pk_q && idx_q > pi_q)) &&
		        (!bf_q || skey < bk_q);

		// line assignment
		lt = 24'(lbx.t);
		lb = 24'(lbx.b);
		st = 24'(skb_q.t);
		sb = 24'(skb_q.b);
		ov = ((lb < sb) ? lb : sb) - ((lt > st) ? lt : st);
		rf = ((lb - lt) < (sb - st)) ? (lb - lt) : (sb - st);
		c2 = st + sb;
		p_ov = 32'(ov) * 32'(signed'({1'b0, ovd_q}));
		p_rf = 32'(rf) * 32'(signed'({1'b0, ovn_q}));
		a_take = ((rf > 24'sd0 && p_ov > p_rf) || (c2 >= (lt <<< 1) && c2 <= (lb <<< 1))) &&
		         ov > bestov_q;

		// tiny mark test on line a
		hh = lb - lt;
		ww = 24'(lbx.r) - 24'(lbx.l);
		tiny24 = 24'({1'b0, tiny_q});
		tiny_ok = (lsz == CW'(1)) && hh < tiny24 && ww < tiny24;

		// nearest line for a tiny mark
		ca   = 24'(abox_q.t) + 24'(abox_q.b);
		dd   = lt + lb - ca;
		dabs = (dd < 24'sd0) ? -dd : dd;
		hk   = lb - lt;
		p_d  = 32'(dabs) * 32'(signed'({1'b0, nd_q}));
		p_h  = 32'(hk) * 32'(signed'({1'b0, nn_q, 1'b0}));
		m_take = (idx_q != a_q) && (!af_q || dabs < bd_q) && p_d < p_h;

		// relabel strokes of the merged line, then close the gap
		rel_v1 = (sl_rd == a_q) ? bl_q : sl_rd;
		rel_v2 = (rel_v1 > a_q) ? rel_v1 - AW'(1) : rel_v1;

		// line order by top
		tkey  = 22'(lbx.t);
		ttake = (!lhp_q || tkey > lpk_q || (tkey == lpk_q && idx_q > lpi_q)) &&
		        (!bf_q || tkey < lbk_q);

		// strokes of line L by raw left edge
		pkey  = 22'(raw.l);
		pcand = (sl_rd == L_q) &&
		        (!hp_q || pkey > pk_q || (pkey == pk_q && idx_q > pi_q));
		ptake = pcand && (!bf_q || pkey < bk_q);
	end

	always_comb begin
		st_we    = (state_q == ST_IDLE) && in_valid && keep && !full;
		st_waddr = cnt_q[AW-1:0];

		sl_we    = 1'b0;
		sl_waddr = bi_q;
		sl_wdata = af_q ? bl_q : lc_q[AW-1:0];
		ln_we    = 1'b0;
		ln_waddr = af_q ? bl_q : lc_q[AW-1:0];
		ln_wdata = af_q ? {lsize_q + CW'(1), un_a} : {CW'(1), skb_q};
		ln_raddr = idx_q;
		case (state_q)
			ST_A_DO: begin
				sl_we = 1'b1;
				ln_we = 1'b1;
			end
			ST_M_WR: begin
				ln_we    = af_q;
				ln_waddr = bl_q;
				ln_wdata = {lsize_q + CW'(1), un_m};
			end
			ST_R_EV: begin
				sl_we    = 1'b1;
				sl_waddr = idx_q;
				sl_wdata = rel_v2;
			end
			ST_M_RDA, ST_M_EVA: begin
				ln_raddr = a_q;
			end
			ST_H_RD: begin
				ln_raddr = idx_q + AW'(1);
			end
			ST_H_EV: begin
				ln_raddr = idx_q + AW'(1);
				ln_we    = 1'b1;
				ln_waddr = idx_q;
				ln_wdata = ln_rd;
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inset_q <= RST_INSET;
			ovn_q   <= RST_OVL_NUM;
			ovd_q   <= RST_OVL_DEN;
			tiny_q  <= RST_TINY;
			nn_q    <= RST_NEAR_NUM;
			nd_q    <= RST_NEAR_DEN;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INSET:    inset_q <= cfg_data[7:0];
				CFG_OVL_NUM:  ovn_q   <= cfg_data[4:0];
				CFG_OVL_DEN:  ovd_q   <= cfg_data[4:0];
				CFG_TINY:     tiny_q  <= cfg_data;
				CFG_NEAR_NUM: nn_q    <= cfg_data[4:0];
				CFG_NEAR_DEN: nd_q    <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lc_q        <= '0;
			rank_q      <= '0;
			drop_q      <= 1'b0;
			idx_q       <= '0;
			a_q         <= '0;
			hp_q        <= 1'b0;
			lhp_q       <= 1'b0;
			bf_q        <= 1'b0;
			af_q        <= 1'b0;
			more_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (keep && !full) cnt_q <= cnt_q + CW'(1);
						if (keep && full) drop_q <= 1'b1;
						if (in_data.set_last) begin
							if (cnt_q == '0 && !keep) begin
								drop_q <= 1'b0;
							end else begin
								rank_q  <= '0;
								lc_q    <= '0;
								hp_q    <= 1'b0;
								bf_q    <= 1'b0;
								idx_q   <= '0;
								state_q <= ST_S_RD;
							end
						end
					end
				end
				ST_S_RD: state_q <= ST_S_EV;
				ST_S_EV: begin
					if (stake) begin
						bf_q  <= 1'b1;
						bk_q  <= skey;
						bi_q  <= idx_q;
						skb_q <= skb_new;
					end
					if (last_n) begin
						idx_q    <= '0;
						af_q     <= 1'b0;
						bestov_q <= '0;
						state_q  <= (lc_q == '0) ? ST_A_DO : ST_A_RD;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_S_RD;
					end
				end
				ST_A_RD: state_q <= ST_A_EV;
				ST_A_EV: begin
					if (a_take) begin
						af_q     <= 1'b1;
						bestov_q <= ov;
						bl_q     <= idx_q;
						lbox_q   <= lbx;
						lsize_q  <= lsz;
					end
					if (last_l) begin
						state_q <= ST_A_DO;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_A_RD;
					end
				end
				ST_A_DO: begin
					if (!af_q) lc_q <= lc_q + CW'(1);
					pk_q   <= bk_q;
					pi_q   <= bi_q;
					hp_q   <= 1'b1;
					bf_q   <= 1'b0;
					idx_q  <= '0;
					rank_q <= rank_q + CW'(1);
					if (rank_q + CW'(1) == cnt_q) begin
						a_q     <= a_next;
						state_q <= ST_M_RDA;
					end else begin
						state_q <= ST_S_RD;
					end
				end
				ST_M_RDA: state_q <= ST_M_EVA;
				ST_M_EVA: begin
					abox_q <= lbx;
					if (tiny_ok) begin
						idx_q   <= '0;
						af_q    <= 1'b0;
						state_q <= ST_M_RD;
					end else begin
						state_q <= ST_M_NXT;
					end
				end
				ST_M_RD: state_q <= ST_M_EV;
				ST_M_EV: begin
					if (m_take) begin
						af_q    <= 1'b1;
						bd_q    <= dabs;
						bl_q    <= idx_q;
						lbox_q  <= lbx;
						lsize_q <= lsz;
					end
					if (last_l) begin
						state_q <= ST_M_WR;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_M_RD;
					end
				end
				ST_M_WR: begin
					idx_q   <= '0;
					state_q <= af_q ? ST_R_RD : ST_M_NXT;
				end
				ST_M_NXT: begin
					if (a_q == '0) begin
						rank_q  <= '0;
						lhp_q   <= 1'b0;
						bf_q    <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_T_RD;
					end else begin
						a_q     <= a_q - AW'(1);
						state_q <= ST_M_RDA;
					end
				end
				ST_R_RD: state_q <= ST_R_EV;
				ST_R_EV: begin
					if (!last_n) begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_R_RD;
					end else if (a_top) begin
						lc_q    <= lc_m1;
						state_q <= ST_M_NXT;
					end else begin
						idx_q   <= a_q;
						state_q <= ST_H_RD;
					end
				end
				ST_H_RD: state_q <= ST_H_EV;
				ST_H_EV: begin
					if (h_last) begin
						lc_q    <= lc_m1;
						state_q <= ST_M_NXT;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_H_RD;
					end
				end
				ST_T_RD: state_q <= ST_T_EV;
				ST_T_EV: begin
					if (ttake) begin
						bf_q  <= 1'b1;
						lbk_q <= tkey;
						L_q   <= idx_q;
					end
					if (last_l) begin
						idx_q   <= '0;
						hp_q    <= 1'b0;
						bf_q    <= 1'b0;
						more_q  <= 1'b0;
						state_q <= ST_P_RD;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_T_RD;
					end
				end
				ST_P_RD: state_q <= ST_P_EV;
				ST_P_EV: begin
					// a second candidate means this is not the line's last stroke
					if (pcand && bf_q) more_q <= 1'b1;
					if (ptake) begin
						bf_q <= 1'b1;
						bk_q <= pkey;
						bi_q <= idx_q;
					end
					if (last_n) begin
						state_q <= ST_P_ID;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_P_RD;
					end
				end
				ST_P_ID: state_q <= ST_P_LD;
				ST_P_LD: begin
					out_q.out_stroke_id <= id_rd;
					out_q.line_index    <= rank_q[5:0];
					out_q.line_end      <= !more_q;
					out_q.set_end       <= !more_q && (rank_q + CW'(1) == lc_q);
					out_q.overflow      <= drop_q;
					out_valid_q         <= 1'b1;
					state_q             <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						pk_q  <= bk_q;
						pi_q  <= bi_q;
						hp_q  <= 1'b1;
						idx_q <= '0;
						bf_q  <= 1'b0;
						if (out_q.set_end) begin
							cnt_q   <= '0;
							lc_q    <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else if (out_q.line_end) begin
							lpk_q   <= lbk_q;
							lpi_q   <= L_q;
							lhp_q   <= 1'b1;
							rank_q  <= rank_q + CW'(1);
							state_q <= ST_T_RD;
						end else begin
							more_q  <= 1'b0;
							state_q <= ST_P_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT)
		else $error("result shown outside the output state");

	a_lines_le_strokes: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= cnt_q)
		else $error("more lines than strokes");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_STROKES))
		else $error("stroke count beyond capacity");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input taken while a result is pending");

	a_set_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.set_end |=> cnt_q == '0 && !drop_q)
		else $error("set state not cleared after the final item");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import isg_pkg::*;

	localparam int MAXS = 64;

	typedef struct {
		longint l, t, r, b;
	} wbox_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ink_stroke_line_grouper #(.MAX_STROKES(MAXS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// grouping settings mirrored from the register writes
	longint g_inset = RST_INSET, g_ovl_num = RST_OVL_NUM, g_ovl_den = RST_OVL_DEN;
	longint g_tiny = RST_TINY, g_near_num = RST_NEAR_NUM, g_near_den = RST_NEAR_DEN;

	// strokes held for the current set
	wbox_t held_box[MAXS];
	logic [31:0] held_id[MAXS];
	int held_cnt = 0;
	bit held_drop = 0;

	in_item_t stroke_fifo[$];
	out_item_t reading_order[$];
	int n_issued = 0;
	int n_taken = 0;
	int errors = 0;
	int kept_sent = 0;
	bit no_idle = 0;
	int in_gap = 0;
	int out_hold = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint lmin(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic wbox_t join_box(wbox_t d, wbox_t s);
		wbox_t r;
		if (d.r - d.l == 0 && d.b - d.t == 0) begin
			r = s;
		end else if (s.r - s.l == 0 && s.b - s.t == 0) begin
			r = d;
		end else begin
			r.l = lmin(lmin(d.l, d.r), lmin(s.l, s.r));
			r.r = lmax(lmax(d.l, d.r), lmax(s.l, s.r));
			r.t = lmin(lmin(d.t, d.b), lmin(s.t, s.b));
			r.b = lmax(lmax(d.t, d.b), lmax(s.t, s.b));
		end
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (no_idle || r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// group the held strokes into lines and queue the ids in reading order
	task automatic group_held();
		wbox_t kb[MAXS];
		wbox_t lb[MAXS];
		int ord[MAXS];
		int tmp[MAXS];
		int lsz[MAXS];
		int sl[MAXS];
		out_item_t res[$];
		out_item_t o;
		int n, i, k, v, ln, best, lc, a, j, c, s, r;
		longint ov, rf, c2, bestov, h, w, ca, d, hk, bd;
		bit ins, pass;
		n = held_cnt;
		for (i = 0; i < n; i++) begin
			kb[i].l = held_box[i].l + g_inset;
			kb[i].t = held_box[i].t + g_inset;
			kb[i].r = held_box[i].r - g_inset;
			kb[i].b = held_box[i].b - g_inset;
		end
		for (i = 0; i < n; i++) begin
			v = i;
			k = i;
			while (k > 0 && kb[ord[k-1]].t + kb[ord[k-1]].b > kb[v].t + kb[v].b) begin
				ord[k] = ord[k-1];
				k--;
			end
			ord[k] = v;
		end
		lc = 0;
		for (i = 0; i < n; i++) begin
			s = ord[i];
			best = -1;
			bestov = 0;
			for (ln = 0; ln < lc; ln++) begin
				ov = lmin(lb[ln].b, kb[s].b) - lmax(lb[ln].t, kb[s].t);
				rf = lmin(lb[ln].b - lb[ln].t, kb[s].b - kb[s].t);
				c2 = kb[s].t + kb[s].b;
				ins = c2 >= 2 * lb[ln].t && c2 <= 2 * lb[ln].b;
				pass = (rf > 0 && ov * g_ovl_den > g_ovl_num * rf) || ins;
				if (pass && ov > bestov) begin
					bestov = ov;
					best = ln;
				end
			end
			if (best >= 0) begin
				lb[best] = join_box(lb[best], kb[s]);
				lsz[best]++;
				sl[s] = best;
			end else begin
				lb[lc] = kb[s];
				lsz[lc] = 1;
				sl[s] = lc;
				lc++;
			end
		end
		// fold tiny single-stroke lines into the nearest line
		for (a = lc - 1; a >= 0; a--) begin
			h = lb[a].b - lb[a].t;
			w = lb[a].r - lb[a].l;
			if (lsz[a] != 1 || h >= g_tiny || w >= g_tiny) continue;
			j = -1;
			bd = 0;
			ca = lb[a].t + lb[a].b;
			for (k = 0; k < lc; k++) begin
				if (k == a) continue;
				d = lb[k].t + lb[k].b - ca;
				hk = lb[k].b - lb[k].t;
				if (d < 0) d = -d;
				if ((j < 0 || d < bd) && d * g_near_den < 2 * hk * g_near_num) begin
					bd = d;
					j = k;
				end
			end
			if (j < 0) continue;
			lb[j] = join_box(lb[j], lb[a]);
			lsz[j] += lsz[a];
			for (i = 0; i < n; i++) if (sl[i] == a) sl[i] = j;
			for (k = a; k + 1 < lc; k++) begin
				lb[k] = lb[k+1];
				lsz[k] = lsz[k+1];
			end
			lc--;
			for (i = 0; i < n; i++) if (sl[i] > a) sl[i]--;
		end
		for (r = 0; r < lc; r++) begin
			v = r;
			k = r;
			while (k > 0 && lb[ord[k-1]].t > lb[v].t) begin
				ord[k] = ord[k-1];
				k--;
			end
			ord[k] = v;
		end
		for (r = 0; r < lc; r++) begin
			ln = ord[r];
			c = 0;
			for (i = 0; i < n; i++) begin
				if (sl[i] != ln) continue;
				k = c;
				c++;
				while (k > 0 && held_box[tmp[k-1]].l > held_box[i].l) begin
					tmp[k] = tmp[k-1];
					k--;
				end
				tmp[k] = i;
			end
			for (k = 0; k < c; k++) begin
				o.out_stroke_id = held_id[tmp[k]];
				o.line_index = 6'(r);
				o.line_end = (k + 1 == c);
				o.set_end = 1'b0;
				o.overflow = held_drop;
				res.push_back(o);
			end
		end
		if (res.size() > 0) begin
			o = res.pop_back();
			o.set_end = 1'b1;
			res.push_back(o);
		end
		foreach (res[q]) reading_order.push_back(res[q]);
	endtask

	// input side: accept, predict
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			n_taken <= n_taken + 1;
			if (in_data.is_pen && in_data.has_points) begin
				if (held_cnt < MAXS) begin
					held_id[held_cnt] = in_data.stroke_id;
					held_box[held_cnt].l = in_data.box_left;
					held_box[held_cnt].t = in_data.box_top;
					held_box[held_cnt].r = in_data.box_right;
					held_box[held_cnt].b = in_data.box_bottom;
					held_cnt++;
				end else begin
					held_drop = 1;
				end
			end
			if (in_data.set_last) begin
				group_held();
				held_cnt = 0;
				held_drop = 0;
			end
		end
	end

	// output side: check against oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (reading_order.size() == 0) begin
				$error("unexpected result id %0h", out_data.out_stroke_id);
				errors++;
			end else begin
				e = reading_order.pop_front();
				if (out_data.out_stroke_id !== e.out_stroke_id) begin
					$error("out_stroke_id exp %0h got %0h", e.out_stroke_id,
						out_data.out_stroke_id);
					errors++;
				end
				if (out_data.line_index !== e.line_index) begin
					$error("line_index exp %0d got %0d", e.line_index, out_data.line_index);
					errors++;
				end
				if (out_data.line_end !== e.line_end) begin
					$error("line_end exp %0b got %0b", e.line_end, out_data.line_end);
					errors++;
				end
				if (out_data.set_end !== e.set_end) begin
					$error("set_end exp %0b got %0b", e.set_end, out_data.set_end);
					errors++;
				end
				if (out_data.overflow !== e.overflow) begin
					$error("overflow exp %0b got %0b", e.overflow, out_data.overflow);
					errors++;
				end
			end
		end
	end

	// stroke driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || n_taken == n_issued) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (stroke_fifo.size() > 0) begin
				in_data <= stroke_fifo.pop_front();
				in_valid <= 1'b1;
				n_issued++;
				in_gap = gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_hold--;
			out_stall <= 1'b1;
		end else begin
			out_hold = gap_len();
			out_stall <= (out_hold > 0);
			if (out_hold > 0) out_hold--;
		end
	end

	function automatic in_item_t mk(logic [31:0] id, bit pen, bit pts,
			int l, int t, int r, int b, bit last);
		in_item_t it;
		it.stroke_id = id;
		it.is_pen = pen;
		it.has_points = pts;
		it.box_left = 20'(l);
		it.box_top = 20'(t);
		it.box_right = 20'(r);
		it.box_bottom = 20'(b);
		it.set_last = last;
		return it;
	endfunction

	task automatic push(in_item_t it);
		stroke_fifo.push_back(it);
		if (it.is_pen && it.has_points) kept_sent++;
	endtask

	task automatic drain();
		wait (stroke_fifo.size() == 0 && n_taken == n_issued && !in_valid);
		wait (reading_order.size() == 0);
		repeat (100) @(posedge clk);
		wait (!in_stall);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_INSET: g_inset = val[7:0];
			CFG_OVL_NUM: g_ovl_num = val[4:0];
			CFG_OVL_DEN: g_ovl_den = val[4:0];
			CFG_TINY: g_tiny = val[11:0];
			CFG_NEAR_NUM: g_near_num = val[4:0];
			CFG_NEAR_DEN: g_near_den = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic gen_set(int n);
		int nl, j, k, x, y, p, shx, shy;
		in_item_t it;
		nl = $urandom_range(1, 4);
		shx = ($urandom_range(0, 5) == 0) ? -int'($urandom_range(0, 500000)) : 0;
		shy = ($urandom_range(0, 5) == 0) ? -int'($urandom_range(0, 500000)) : 0;
		for (j = 0; j < n; j++) begin
			k = $urandom_range(0, 19);
			y = int'($urandom_range(0, nl - 1)) * 700 + shy;
			x = int'($urandom_range(0, 6000)) + shx;
			if (k == 0) begin
				p = $urandom_range(0, 2);
				it = mk($urandom, p == 1, p == 2, x, y, x + 300, y + 300, 0);
			end else if (k == 1) begin
				it = mk($urandom, 1, 1, $urandom, $urandom, $urandom, $urandom, 0);
			end else if (k == 2) begin
				y = y + int'($urandom_range(0, 300));
				it = mk($urandom, 1, 1, x, y, x + int'($urandom_range(0, 100)),
					y + int'($urandom_range(0, 100)), 0);
			end else begin
				y = y + int'($urandom_range(0, 120)) - 60;
				it = mk($urandom, 1, 1, x, y, x + int'($urandom_range(20, 600)),
					y + int'($urandom_range(120, 420)), 0);
			end
			it.set_last = (j == n - 1);
			push(it);
		end
	endtask

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int ph, quota, sets;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, tiny marks, ties, ignored strokes, empty set
		push(mk(32'h0, 1, 1, 0, 0, 0, 0, 1));
		push(mk(32'hFFFFFFFF, 1, 1, -524288, -524288, 524287, 524287, 0));
		push(mk(32'h1, 1, 1, 524287, 524287, -524288, -524288, 0));
		push(mk(32'h2, 0, 1, 0, 0, 100, 100, 0));
		push(mk(32'h3, 1, 0, 0, 0, 100, 100, 1));
		push(mk(32'h10, 0, 0, 0, 0, 10, 10, 1));
		push(mk(32'h11, 1, 1, 100, 100, 400, 400, 0));
		push(mk(32'h12, 1, 1, 100, 100, 400, 400, 0));
		push(mk(32'h13, 1, 1, 500, 120, 800, 380, 0));
		push(mk(32'h14, 1, 1, 900, 180, 960, 240, 0));
		push(mk(32'h15, 1, 1, 300, 900, 700, 1200, 0));
		push(mk(32'h16, 1, 1, 200, 500, 260, 560, 0));
		push(mk(32'h17, 1, 1, 64, 64, 64, 64, 1));
		push(mk(32'h18, 1, 1, 0, 0, 400, 300, 0));
		push(mk(32'h19, 1, 1, 500, 1000, 900, 1300, 0));
		push(mk(32'h1A, 1, 1, 1000, 0, 1400, 300, 1));
		drain();

		for (ph = 0; ph < 6; ph++) begin
			no_idle = (ph == 2);
			case (ph)
				0: begin
					cfg_write(CFG_INSET, 0); cfg_write(CFG_OVL_NUM, 0);
					cfg_write(CFG_OVL_DEN, 0); cfg_write(CFG_TINY, 0);
					cfg_write(CFG_NEAR_NUM, 0); cfg_write(CFG_NEAR_DEN, 0);
				end
				1: begin
					cfg_write(CFG_INSET, 255); cfg_write(CFG_OVL_NUM, 16);
					cfg_write(CFG_OVL_DEN, 16); cfg_write(CFG_TINY, 4095);
					cfg_write(CFG_NEAR_NUM, 16); cfg_write(CFG_NEAR_DEN, 16);
				end
				2: begin
					cfg_write(CFG_INSET, RST_INSET); cfg_write(CFG_OVL_NUM, RST_OVL_NUM);
					cfg_write(CFG_OVL_DEN, RST_OVL_DEN); cfg_write(CFG_TINY, RST_TINY);
					cfg_write(CFG_NEAR_NUM, RST_NEAR_NUM);
					cfg_write(CFG_NEAR_DEN, RST_NEAR_DEN);
				end
				3: begin
					cfg_write(CFG_INSET, 8); cfg_write(CFG_OVL_NUM, 31);
					cfg_write(CFG_OVL_DEN, 1); cfg_write(CFG_TINY, 200);
					cfg_write(CFG_NEAR_NUM, 31); cfg_write(CFG_NEAR_DEN, 0);
				end
				default: begin
					cfg_write(CFG_INSET, $urandom_range(0, 255));
					cfg_write(CFG_OVL_NUM, $urandom_range(0, 31));
					cfg_write(CFG_OVL_DEN, $urandom_range(0, 31));
					cfg_write(CFG_TINY, $urandom_range(0, 4095));
					cfg_write(CFG_NEAR_NUM, $urandom_range(0, 31));
					cfg_write(CFG_NEAR_DEN, $urandom_range(0, 31));
				end
			endcase
			quota = kept_sent + 16;
			sets = 0;
			while (kept_sent < quota) begin
				// large sets, at times past capacity, now and then
				if (ph == 1 || ph == 4 && sets == 0) gen_set($urandom_range(62, 70));
				else gen_set($urandom_range(1, 12));
				sets++;
				if (ph == 3 && sets == 2) drain();
				if (ph == 1) break;
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (errors == 0 && reading_order.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
